/* src/uet_pkg.sv */
// Shared types and constants for the undirected edge table.
package uet_pkg;

  localparam int unsigned VTX_W    = 8;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned CAP_W    = 11;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned ENTRY_W  = 2 * VTX_W + WGT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_LOOP    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DUP     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_MISSING = 3'd4;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
    logic [WGT_W-1:0] weight_bits;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WGT_W-1:0]  weight_out;
    logic [CAP_W-1:0]  edge_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DEL_RD,
    ST_DEL_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              scan_clr;
    logic              scan_en;
    logic              hole_ld;
    logic              rd_last;
    logic              wr_append;
    logic              wr_move;
    logic              respond;
    logic [STAT_W-1:0] resp_status;
    logic              resp_weight;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic full;
    logic loop;
    logic hit;
    logic scan_done;
  } dp_stat_t;

endpackage

/* src/uet_ctrl.sv */
// Controller state machine for the undirected edge table.
module uet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  uet_pkg::dp_stat_t stat,
  output uet_pkg::cmd_t     cmd
);

  uet_pkg::state_t state_r;
  uet_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uet_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != uet_pkg::ST_IDLE);
    case (state_r)
      uet_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = uet_pkg::ST_DECIDE;
        end
      end
      uet_pkg::ST_DECIDE: begin
        case (stat.op)
          uet_pkg::OP_ADD: begin
            if (stat.full) begin
              cmd.respond     = 1'b1;
              cmd.resp_status = uet_pkg::STAT_FULL;
              state_nxt       = uet_pkg::ST_IDLE;
            end else if (stat.loop) begin
              cmd.respond     = 1'b1;
              cmd.resp_status = uet_pkg::STAT_LOOP;
              state_nxt       = uet_pkg::ST_IDLE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = uet_pkg::ST_SCAN;
            end
          end
          uet_pkg::OP_DEL, uet_pkg::OP_LOOKUP: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = uet_pkg::ST_SCAN;
          end
          default: begin
            cmd.respond     = 1'b1;
            cmd.resp_status = uet_pkg::STAT_OK;
            state_nxt       = uet_pkg::ST_IDLE;
          end
        endcase
      end
      uet_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.hit) begin
          case (stat.op)
            uet_pkg::OP_ADD: begin
              cmd.respond     = 1'b1;
              cmd.resp_status = uet_pkg::STAT_DUP;
              state_nxt       = uet_pkg::ST_IDLE;
            end
            uet_pkg::OP_DEL: begin
              cmd.hole_ld = 1'b1;
              state_nxt   = uet_pkg::ST_DEL_RD;
            end
            default: begin
              cmd.respond     = 1'b1;
              cmd.resp_status = uet_pkg::STAT_OK;
              cmd.resp_weight = 1'b1;
              state_nxt       = uet_pkg::ST_IDLE;
            end
          endcase
        end else if (stat.scan_done) begin
          cmd.respond = 1'b1;
          state_nxt   = uet_pkg::ST_IDLE;
          if (stat.op == uet_pkg::OP_ADD) begin
            cmd.wr_append   = 1'b1;
            cmd.resp_status = uet_pkg::STAT_OK;
          end else begin
            cmd.resp_status = uet_pkg::STAT_MISSING;
          end
        end
      end
      uet_pkg::ST_DEL_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = uet_pkg::ST_DEL_WR;
      end
      uet_pkg::ST_DEL_WR: begin
        cmd.wr_move     = 1'b1;
        cmd.respond     = 1'b1;
        cmd.resp_status = uet_pkg::STAT_OK;
        state_nxt       = uet_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = uet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/uet_dp.sv */
// Datapath for the undirected edge table: edge memory, scan counter and result register.
module uet_dp #(
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  uet_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [uet_pkg::CAP_W-1:0]      cfg_wdata,
  input  uet_pkg::cmd_t                  cmd,
  output uet_pkg::dp_stat_t              stat,
  output logic                           out_valid,
  output uet_pkg::out_item_t             out_item
);

  localparam int unsigned CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int unsigned ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CMP_W  = (CNT_W > uet_pkg::CAP_W) ? CNT_W : uet_pkg::CAP_W;

  logic [uet_pkg::ENTRY_W-1:0] mem [MAX_EDGES];

  uet_pkg::in_item_t           item_r;
  logic [uet_pkg::CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic [CNT_W-1:0]            last_idx;
  logic [CNT_W-1:0]            issue_idx_r;
  logic                        chk_vld_r;
  logic [ADDR_W-1:0]           chk_idx_r;
  logic [ADDR_W-1:0]           hole_r;
  logic [uet_pkg::ENTRY_W-1:0] rd_data_r;
  logic                        issue_done;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [uet_pkg::ENTRY_W-1:0] wr_data;
  logic [CMP_W-1:0]            count_ext;
  logic [CMP_W-1:0]            cap_ext;
  logic [CMP_W-1:0]            cnt_out_ext;
  logic                        match;
  logic                        out_valid_r;
  uet_pkg::out_item_t          out_item_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= uet_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign last_idx   = count_r - CNT_W'(1);
  assign issue_done = (issue_idx_r == count_r);

  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_append) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.wr_move) begin
      count_nxt = last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Scan counter: one read issued per cycle, compared in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_idx_r <= '0;
      chk_vld_r   <= 1'b0;
    end else if (cmd.scan_clr) begin
      issue_idx_r <= '0;
      chk_vld_r   <= 1'b0;
    end else if (cmd.scan_en) begin
      if (!issue_done) begin
        issue_idx_r <= issue_idx_r + CNT_W'(1);
        chk_vld_r   <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && !issue_done) begin
      chk_idx_r <= issue_idx_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hole_ld) begin
      hole_r <= chk_idx_r;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_idx_r[ADDR_W-1:0];
    if (cmd.scan_en && !issue_done) begin
      rd_en = 1'b1;
    end else if (cmd.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[ADDR_W-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.wr_append | cmd.wr_move;
    wr_addr = count_r[ADDR_W-1:0];
    wr_data = {item_r.weight_bits, item_r.vertex_b, item_r.vertex_a};
    if (cmd.wr_move) begin
      wr_addr = hole_r;
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign match = ((rd_data_r[7:0] == item_r.vertex_a) && (rd_data_r[15:8] == item_r.vertex_b))
              || ((rd_data_r[7:0] == item_r.vertex_b) && (rd_data_r[15:8] == item_r.vertex_a));

  assign count_ext = CMP_W'(count_r);
  assign cap_ext   = CMP_W'(cap_r);

  always_comb begin
    stat           = '0;
    stat.op        = uet_pkg::op_t'(item_r.op);
    stat.full      = (count_ext >= cap_ext) || (count_r == CNT_W'(MAX_EDGES));
    stat.loop      = (item_r.vertex_a == item_r.vertex_b);
    stat.hit       = chk_vld_r && match;
    stat.scan_done = issue_done && !chk_vld_r;
  end

  assign cnt_out_ext = CMP_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_item_r.status     <= cmd.resp_status;
      out_item_r.weight_out <= cmd.resp_weight ? rd_data_r[uet_pkg::ENTRY_W-1:16]
                                               : '0;
      out_item_r.edge_count <= cnt_out_ext[uet_pkg::CAP_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* src/undirected_edge_table.sv */
// Top level of the undirected edge table: controller plus datapath.
//
//   Channel   Ports                         Direction  Handshake
//   input     start, busy, in_item          in         taken when start=1 and busy=0
//   result    out_valid, out_item           out        one-cycle strobe, cannot stall
//   config    cfg_we, cfg_wdata             in         written when cfg_we=1
//
// An item is decoded first, then scans the table one entry per cycle through
// the single read port of the edge memory. Each entry's read data is
// registered and compared in the cycle after the read. An add that goes in,
// or a lookup or delete that misses, raises the result strobe once the scan
// has passed every held edge. A lookup or a duplicate add answers once the
// edge is found; a found delete then fetches the last entry and writes it
// into the hole. A refused add (full or loop) and a reserved op answer from
// the decode step, with no scan. The edge memory has no reset; only entries
// below the edge count are ever read. Reset (rst_n low at a clock edge)
// empties the table and sets the capacity to 1024. The result strobe lasts
// one cycle and the receiver has no way to hold it off.
module undirected_edge_table #(
  parameter int unsigned MAX_EDGES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  uet_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output uet_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [uet_pkg::CAP_W-1:0] cfg_wdata
);

  // Commands flow from the controller to the datapath; status flows back.
  uet_pkg::cmd_t     cmd;
  uet_pkg::dp_stat_t stat;

  // The controller sequences decode, scan and the delete move.
  uet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the edge memory, the count, the capacity and the
  // registered result.
  uet_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
